/* hw/rtl/prbs_byte_generator_checker_assert.svh */
// assertion macros used by the prbs port-level checker file
`ifndef PRBS_BYTE_GENERATOR_CHECKER_ASSERT_SVH
`define PRBS_BYTE_GENERATOR_CHECKER_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, off during reset
`define PBGC_ASSERT_IMPL(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error("pbgc assertion failed");

// next-cycle implication
`define PBGC_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error("pbgc assertion failed");

`endif

/* hw/rtl/pbgc_pkg.sv */
// types, constants and lfsr helper functions for the prbs byte engine
package pbgc_pkg;

    localparam int WORD_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int ERR_W       = 4;
    localparam int SEED_CNT_W  = 3;
    localparam int CFG_INDEX_W = 2;

    localparam logic [SEED_CNT_W-1:0] SEED_BYTES = 3'd4;
    localparam logic [WORD_W-1:0]     WORD_ALL_ONES = 32'hffff_ffff;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_MODE          = 2'd0,
        CFG_POLYNOMIAL    = 2'd1,
        CFG_RX_FLIP       = 2'd2
    } cfg_index_t;

    typedef enum logic {
        MODE_GENERATE = 1'b0,
        MODE_CHECK    = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t              mode;
        logic [WORD_W-1:0]  polynomial;
        logic [BYTE_W-1:0]  rx_flip;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              block_start;
    } item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [ERR_W-1:0]  byte_errors;
        logic [WORD_W-1:0] block_errors;
        logic              seeding;
    } result_t;

    // eight fibonacci clocks: shift left, parity of tapped bits into bit 0
    function automatic logic [WORD_W-1:0] lfsr_advance_byte(
        input logic [WORD_W-1:0] word,
        input logic [WORD_W-1:0] poly
    );
        logic [WORD_W-1:0] w;
        w = word;
        for (int k = 0; k < BYTE_W; k++) begin
            w = {w[WORD_W-2:0], ^(w & poly)};
        end
        return w;
    endfunction

    // smallest 2^k-1 not below poly: smear the top set bit downward
    function automatic logic [WORD_W-1:0] start_word(input logic [WORD_W-1:0] poly);
        logic [WORD_W-1:0] w;
        w = poly;
        w = w | (w >> 1);
        w = w | (w >> 2);
        w = w | (w >> 4);
        w = w | (w >> 8);
        w = w | (w >> 16);
        return w;
    endfunction

    function automatic logic [ERR_W-1:0] popcount8(input logic [BYTE_W-1:0] b);
        logic [ERR_W-1:0] n;
        n = '0;
        for (int k = 0; k < BYTE_W; k++) begin
            n = n + {{(ERR_W-1){1'b0}}, b[k]};
        end
        return n;
    endfunction

endpackage

/* hw/rtl/pbgc_if.sv */
// stream and configuration channel interfaces

interface pbgc_item_if;
    logic                          valid;
    logic                          ready;
    logic [pbgc_pkg::BYTE_W-1:0]   rx_byte;
    logic                          block_start;

    modport source (output valid, output rx_byte, output block_start, input ready);
    modport sink   (input valid, input rx_byte, input block_start, output ready);
endinterface

interface pbgc_result_if;
    logic                          valid;
    logic                          ready;
    logic [pbgc_pkg::BYTE_W-1:0]   out_byte;
    logic [pbgc_pkg::ERR_W-1:0]    byte_errors;
    logic [pbgc_pkg::WORD_W-1:0]   block_errors;
    logic                          seeding;

    modport source (output valid, output out_byte, output byte_errors,
                    output block_errors, output seeding, input ready);
    modport sink   (input valid, input out_byte, input byte_errors,
                    input block_errors, input seeding, output ready);
endinterface

interface pbgc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [pbgc_pkg::CFG_INDEX_W-1:0]  index;
    logic [pbgc_pkg::WORD_W-1:0]       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/pbgc_cfg_regs.sv */
// configuration register file: mode, polynomial, polarity mask
module pbgc_cfg_regs (
    input  logic             clk,
    input  logic             rst_n,
    pbgc_cfg_if.sink         cfg,
    output pbgc_pkg::cfg_t   cfg_out
);

    pbgc_pkg::cfg_t cfg_reg;
    pbgc_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                pbgc_pkg::CFG_MODE:
                    cfg_next.mode = pbgc_pkg::mode_t'(cfg.data[0]);
                pbgc_pkg::CFG_POLYNOMIAL:
                    cfg_next.polynomial = cfg.data;
                pbgc_pkg::CFG_RX_FLIP:
                    cfg_next.rx_flip = cfg.data[pbgc_pkg::BYTE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{mode: pbgc_pkg::MODE_GENERATE, polynomial: '0, rx_flip: '0};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_out = cfg_reg;

endmodule

/* hw/rtl/pbgc_engine.sv */
// lfsr state, seeding, byte compare and saturating error total
module pbgc_engine (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  pbgc_pkg::item_t     item,
    input  pbgc_pkg::cfg_t      cfg,
    output pbgc_pkg::result_t   result
);

    logic [pbgc_pkg::WORD_W-1:0]     lfsr_word_reg, lfsr_word_next;
    logic [pbgc_pkg::SEED_CNT_W-1:0] seed_cnt_reg, seed_cnt_next;
    logic [pbgc_pkg::WORD_W-1:0]     error_total_reg, error_total_next;

    logic [pbgc_pkg::SEED_CNT_W-1:0] seed_cnt_base;
    logic [pbgc_pkg::WORD_W-1:0]     total_base;
    logic [pbgc_pkg::WORD_W-1:0]     adv_in;
    logic [pbgc_pkg::WORD_W-1:0]     adv_word;
    logic [pbgc_pkg::BYTE_W-1:0]     rx_fixed;
    logic [pbgc_pkg::ERR_W-1:0]      errs;
    logic [pbgc_pkg::WORD_W:0]       total_sum;

    always_comb
    begin
        seed_cnt_base = item.block_start ? '0 : seed_cnt_reg;
        total_base    = item.block_start ? '0 : error_total_reg;
        rx_fixed      = item.rx_byte ^ cfg.rx_flip;

        // one shared eight-step network for both modes
        if (cfg.mode == pbgc_pkg::MODE_GENERATE && item.block_start)
            adv_in = pbgc_pkg::start_word(cfg.polynomial);
        else
            adv_in = lfsr_word_reg;
        adv_word = pbgc_pkg::lfsr_advance_byte(adv_in, cfg.polynomial);

        errs      = pbgc_pkg::popcount8(adv_word[pbgc_pkg::BYTE_W-1:0] ^ rx_fixed);
        total_sum = {1'b0, total_base} + {{(pbgc_pkg::WORD_W+1-pbgc_pkg::ERR_W){1'b0}}, errs};

        lfsr_word_next      = adv_word;
        seed_cnt_next       = seed_cnt_base;
        error_total_next    = total_base;
        result.out_byte     = adv_word[pbgc_pkg::BYTE_W-1:0];
        result.byte_errors  = '0;
        result.seeding      = 1'b0;

        if (cfg.mode == pbgc_pkg::MODE_CHECK)
        begin
            if (seed_cnt_base < pbgc_pkg::SEED_BYTES)
            begin
                lfsr_word_next  = {lfsr_word_reg[pbgc_pkg::WORD_W-pbgc_pkg::BYTE_W-1:0],
                                   rx_fixed};
                seed_cnt_next   = seed_cnt_base + 3'd1;
                result.out_byte = '0;
                result.seeding  = 1'b1;
            end
            else
            begin
                result.byte_errors = errs;
                // saturate on carry out
                error_total_next = total_sum[pbgc_pkg::WORD_W] ? pbgc_pkg::WORD_ALL_ONES
                                                                : total_sum[pbgc_pkg::WORD_W-1:0];
            end
        end
        result.block_errors = error_total_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lfsr_word_reg   <= '0;
            seed_cnt_reg    <= '0;
            error_total_reg <= '0;
        end
        else if (advance)
        begin
            lfsr_word_reg   <= lfsr_word_next;
            seed_cnt_reg    <= seed_cnt_next;
            error_total_reg <= error_total_next;
        end
    end

endmodule

/* hw/rtl/prbs_byte_generator_checker.sv */
// top level of the byte-wide prbs generator and checker
//
//  channel   dir   payload                                          request moves
//  item      in    rx_byte, block_start                             one byte
//  result    out   out_byte, byte_errors, block_errors, seeding     one result
//  cfg       in    index, data                                      one register write
//
//  one request per clock while the result is not stalled: input register, eight-step parity network, result register
//  a taken request waits in the input register until the result register is free to load it and hand it off
//  a stalled result holds; the input register takes one more request, then ready drops
//  rst_n clears the lfsr word, seed count, error total, configuration and valid flags
module prbs_byte_generator_checker (
    input  logic          clk,
    input  logic          rst_n,
    pbgc_item_if.sink     item,
    pbgc_result_if.source result,
    pbgc_cfg_if.sink      cfg
);

    pbgc_pkg::cfg_t    cfg_cur;
    pbgc_pkg::result_t eng_result;

    logic              in_valid_reg, in_valid_next;
    pbgc_pkg::item_t   in_item_reg, in_item_next;
    logic              out_valid_reg, out_valid_next;
    pbgc_pkg::result_t out_result_reg, out_result_next;

    logic out_free;
    logic advance;

    pbgc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_out (cfg_cur)
    );

    pbgc_engine u_engine (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .cfg     (cfg_cur),
        .result  (eng_result)
    );

    assign out_free   = !out_valid_reg || result.ready;
    assign advance    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || advance;

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_item_next    = in_item_reg;
        out_valid_next  = out_valid_reg;
        out_result_next = out_result_reg;
        if (item.ready)
        begin
            in_valid_next = item.valid;
            in_item_next  = '{rx_byte: item.rx_byte, block_start: item.block_start};
        end
        if (out_free)
        begin
            out_valid_next = in_valid_reg;
        end
        if (advance)
        begin
            out_result_next = eng_result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg    <= in_item_next;
        out_result_reg <= out_result_next;
    end

    assign result.valid        = out_valid_reg;
    assign result.out_byte     = out_result_reg.out_byte;
    assign result.byte_errors  = out_result_reg.byte_errors;
    assign result.block_errors = out_result_reg.block_errors;
    assign result.seeding      = out_result_reg.seeding;

endmodule

/* hw/rtl/pbgc_checker.sv */
// port-level assertions on the result channel, bound to the top level
`include "prbs_byte_generator_checker_assert.svh"

module pbgc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [pbgc_pkg::BYTE_W-1:0]  out_byte,
    input logic [pbgc_pkg::ERR_W-1:0]   byte_errors,
    input logic [pbgc_pkg::WORD_W-1:0]  block_errors,
    input logic                         seeding
);

    // a byte never has more errors than bits
    `PBGC_ASSERT_IMPL(a_err_range, clk, rst_n, out_valid, byte_errors <= 4'd8)

    // seeding bytes are neither predicted nor compared
    `PBGC_ASSERT_IMPL(a_seed_quiet, clk, rst_n, out_valid && seeding,
        out_byte == 8'd0 && byte_errors == 4'd0)

    // the block total already includes this byte
    `PBGC_ASSERT_IMPL(a_total_covers, clk, rst_n, out_valid,
        block_errors >= {28'd0, byte_errors})

    `PBGC_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(out_byte) && $stable(block_errors) && $stable(seeding))

endmodule

bind prbs_byte_generator_checker pbgc_checker u_pbgc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_byte     (result.out_byte),
    .byte_errors  (result.byte_errors),
    .block_errors (result.block_errors),
    .seeding      (result.seeding)
);
